### rtl/toroidal_life_generation_macros.svh
// ---------------------------------------------------------------------------
// toroidal_life_generation_macros.svh
// Assertion macros shared by the toroidal life generation RTL.
// ---------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GENERATION_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define TLG_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication, clocked on clk, off during reset
`define TLG_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define TLG_ASSERT_IMPL(label, pre, post, msg)
`define TLG_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/tlg_pkg.sv
// ---------------------------------------------------------------------------
// tlg_pkg
// Sizes, codes and types shared by the toroidal life generation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlg_pkg;

	// grid storage
	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 128;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W   = $clog2(MAX_COLS + 1);

	// item fields and config registers
	localparam int OP_W       = 2;
	localparam int ROW_FLD_W  = 5;
	localparam int COL_FLD_W  = 7;
	localparam int ROWS_REG_W = 6;
	localparam int COLS_REG_W = 8;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// register indexes (paddr[2])
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// reset sizes
	localparam logic [ROWS_REG_W-1:0] ROWS_RST = ROWS_REG_W'(30);
	localparam logic [COLS_REG_W-1:0] COLS_RST = COLS_REG_W'(90);

	// op codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_ADV   = 2'd2;

	// B3/S23 neighbour counts
	localparam logic [3:0] BIRTH_CNT = 4'd3;
	localparam logic [3:0] KEEP_CNT  = 4'd2;

	typedef logic [MAX_COLS-1:0] row_t;

endpackage

### rtl/tlg_ram.sv
// ---------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/tlg_row_next.sv
// ---------------------------------------------------------------------------
// tlg_row_next
// Next-generation value of one grid row from its old row and the two
// old rows around it, with column wrap at the size in use.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlg_row_next (
	input  tlg_pkg::row_t                above,
	input  tlg_pkg::row_t                mid,
	input  tlg_pkg::row_t                below,
	input  logic [tlg_pkg::CCNT_W-1:0]   nc,
	output tlg_pkg::row_t                nxt
);
	import tlg_pkg::*;

	logic [COL_W-1:0] last_col;
	row_t al, ar, ml, mr, bl, br;
	logic [3:0] cnt [MAX_COLS];

	assign last_col = COL_W'(nc - CCNT_W'(1));

	// left / right neighbours, wrapping at the last column in use
	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			if (j == 0) begin
				al[j] = above[last_col];
				ml[j] = mid[last_col];
				bl[j] = below[last_col];
			end else begin
				al[j] = above[(j + MAX_COLS - 1) % MAX_COLS];
				ml[j] = mid[(j + MAX_COLS - 1) % MAX_COLS];
				bl[j] = below[(j + MAX_COLS - 1) % MAX_COLS];
			end
			if (COL_W'(j) == last_col) begin
				ar[j] = above[0];
				mr[j] = mid[0];
				br[j] = below[0];
			end else begin
				ar[j] = above[(j + 1) % MAX_COLS];
				mr[j] = mid[(j + 1) % MAX_COLS];
				br[j] = below[(j + 1) % MAX_COLS];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			cnt[j] = 4'(al[j]) + 4'(above[j]) + 4'(ar[j]) + 4'(ml[j]) + 4'(mr[j])
			       + 4'(bl[j]) + 4'(below[j]) + 4'(br[j]);
			if (j >= int'(nc)) begin
				nxt[j] = mid[j];	// outside the region: unchanged
			end else begin
				nxt[j] = (cnt[j] == BIRTH_CNT) | ((cnt[j] == KEEP_CNT) & mid[j]);
			end
		end
	end

endmodule

### rtl/toroidal_life_generation.sv
// ---------------------------------------------------------------------------
// toroidal_life_generation
// Toroidal B3/S23 grid engine: cell write, cell read, advance one generation.
// ---------------------------------------------------------------------------
// The grid lives in a 32-row by 128-bit RAM, one row per word, with a
// registered read. Only the top-left rows_in_use x cols_in_use region takes
// part and wraps at its edges; sizes of zero count as one, sizes past the
// grid saturate. Every item gives exactly one result item. An in-range cell
// write is a row read-modify-write, a read a row read and sample; both go
// from acceptance to the result register through row read, modify / sample,
// then the result load. An advance streams the region through the RAM one
// row per cycle: setup reads of row 0, the last row and row 1, then one row
// written per row in use, then the result load; the single RAM read port
// sets that rate. Unused op code 3 returns at once with done_kind 3. No new
// item is taken while one is in flight; a new one is taken while a finished
// result still waits downstream. After reset all cells read as dead at once:
// per-row valid bits stand in for a clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "toroidal_life_generation_macros.svh"

module toroidal_life_generation (
	input  logic                            clk,
	input  logic                            arst_n,
	// config port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tlg_pkg::APB_AW-1:0]      paddr,
	input  logic [tlg_pkg::APB_DW-1:0]      pwdata,
	output logic [tlg_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tlg_pkg::OP_W-1:0]        op,
	input  logic [tlg_pkg::ROW_FLD_W-1:0]   row,
	input  logic [tlg_pkg::COL_FLD_W-1:0]   col,
	input  logic                            write_value,
	// result item channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            read_value,
	output logic [tlg_pkg::OP_W-1:0]        done_kind,
	output logic                            out_of_range
);
	import tlg_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_CELL_RD   = 3'd1;	// row read issued
	localparam logic [2:0] S_CELL_WB   = 3'd2;	// row data back, modify / sample
	localparam logic [2:0] S_ADV_R0    = 3'd3;	// read row 0
	localparam logic [2:0] S_ADV_RL    = 3'd4;	// read last row, row 0 back
	localparam logic [2:0] S_ADV_PRIME = 3'd5;	// read row 1, last row back
	localparam logic [2:0] S_ADV_RUN   = 3'd6;	// one row per cycle
	localparam logic [2:0] S_RESP      = 3'd7;	// load result register

	logic [2:0]            state_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;
	logic [RCNT_W-1:0]     nr;
	logic [CCNT_W-1:0]     nc;

	logic [OP_W-1:0]       op_q;
	logic [ROW_FLD_W-1:0]  row_q;
	logic [COL_FLD_W-1:0]  col_q;
	logic                  wv_q;
	logic                  rd_q;
	logic                  oor_q;

	logic                  out_valid_q;
	logic                  read_value_q;
	logic [OP_W-1:0]       done_kind_q;
	logic                  out_of_range_q;

	logic [MAX_ROWS-1:0]   valid_q;		// row written since reset
	logic                  rvalid_s1;
	logic [ROW_W-1:0]      raddr;
	logic [ROW_W-1:0]      waddr;
	logic                  mem_we;
	row_t                  wdata;
	row_t                  rdata;
	row_t                  rdata_m;

	row_t                  first_q;		// old row 0
	row_t                  prev_q;		// old row above the current one
	row_t                  mid_q;		// old current row
	row_t                  below;
	row_t                  nxt;
	row_t                  cell_row;
	logic [ROW_W-1:0]      row_cnt_q;
	logic                  last_row;

	logic                  accept;
	logic                  in_oor;
	logic                  cfg_wr;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[ROWS_REG_W-1:0];
				REG_COLS: cols_q <= pwdata[COLS_REG_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = APB_DW'(rows_q);
			REG_COLS: prdata = APB_DW'(cols_q);
			default:  prdata = '0;
		endcase
	end

	// clamped sizes in use
	always_comb begin
		if (rows_q == '0) begin
			nr = RCNT_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr = RCNT_W'(MAX_ROWS);
		end else begin
			nr = RCNT_W'(rows_q);
		end
		if (cols_q == '0) begin
			nc = CCNT_W'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			nc = CCNT_W'(MAX_COLS);
		end else begin
			nc = CCNT_W'(cols_q);
		end
	end

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign in_oor   = (int'(row) >= int'(nr)) | (int'(col) >= int'(nc));

	// ------------------------------------------------------------------
	// grid RAM; unwritten rows read as dead
	// ------------------------------------------------------------------
	tlg_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		unique case (state_q)
			S_CELL_RD:   raddr = ROW_W'(row_q);
			S_ADV_R0:    raddr = '0;
			S_ADV_RL:    raddr = ROW_W'(nr - RCNT_W'(1));
			S_ADV_PRIME: raddr = ROW_W'(1);
			S_ADV_RUN:   raddr = ROW_W'(row_cnt_q + ROW_W'(2));	// past the end is ignored
			default:     raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[raddr];
			if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata_m = rvalid_s1 ? rdata : '0;

	// single-cell modify of the row just read
	always_comb begin
		cell_row = rdata_m;
		cell_row[COL_W'(col_q)] = wv_q;
	end

	// ------------------------------------------------------------------
	// generation datapath
	// ------------------------------------------------------------------
	assign last_row = ((RCNT_W'(row_cnt_q) + RCNT_W'(1)) == nr);
	assign below    = last_row ? first_q : rdata_m;	// bottom wraps to old row 0

	tlg_row_next u_next (
		.above (prev_q),
		.mid   (mid_q),
		.below (below),
		.nc    (nc),
		.nxt   (nxt)
	);

	always_comb begin
		mem_we = 1'b0;
		waddr  = ROW_W'(row_q);
		wdata  = cell_row;
		if (state_q == S_CELL_WB && op_q == OP_WRITE) begin
			mem_we = 1'b1;
		end else if (state_q == S_ADV_RUN) begin
			mem_we = 1'b1;
			waddr  = row_cnt_q;
			wdata  = nxt;
		end
	end

	// row copies
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_ADV_RL: begin
				first_q <= rdata_m;
				mid_q   <= rdata_m;
			end
			S_ADV_PRIME: begin
				prev_q <= rdata_m;
			end
			S_ADV_RUN: begin
				prev_q <= mid_q;
				mid_q  <= below;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((op == OP_WRITE || op == OP_READ) && !in_oor) begin
							state_q <= S_CELL_RD;
						end else if (op == OP_ADV) begin
							state_q <= S_ADV_R0;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_CELL_RD:   state_q <= S_CELL_WB;
				S_CELL_WB:   state_q <= S_RESP;
				S_ADV_R0:    state_q <= S_ADV_RL;
				S_ADV_RL:    state_q <= S_ADV_PRIME;
				S_ADV_PRIME: begin
					row_cnt_q <= '0;
					state_q   <= S_ADV_RUN;
				end
				S_ADV_RUN: begin
					row_cnt_q <= row_cnt_q + ROW_W'(1);
					if (last_row) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			row_q <= row;
			col_q <= col;
			wv_q  <= write_value;
			rd_q  <= 1'b0;
			oor_q <= (op == OP_WRITE || op == OP_READ) & in_oor;
		end
		if (state_q == S_CELL_WB && op_q == OP_READ) begin
			rd_q <= rdata_m[COL_W'(col_q)];
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
			read_value_q   <= rd_q;
			done_kind_q    <= op_q;
			out_of_range_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign done_kind    = done_kind_q;
	assign out_of_range = out_of_range_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`TLG_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted item left sequencer idle")
	`TLG_ASSERT_IMPL(a_row_cnt_in_range, state_q == S_ADV_RUN, RCNT_W'(row_cnt_q) < nr, "advance row counter past rows in use")
	`TLG_ASSERT_IMPL(a_we_only_when_busy, mem_we, state_q == S_CELL_WB || state_q == S_ADV_RUN, "grid RAM written outside a write or advance")

endmodule

### tb/tlg_life_checker.sv
// ---------------------------------------------------------------------------
// tlg_life_checker
// Watches the config port and both item channels of the toroidal life block,
// keeps its own grid and sizes, predicts each result item and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlg_life_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tlg_pkg::APB_AW-1:0]       paddr,
	input  logic [tlg_pkg::APB_DW-1:0]       pwdata,
	input  logic                             pready,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [tlg_pkg::OP_W-1:0]         op,
	input  logic [tlg_pkg::ROW_FLD_W-1:0]    row,
	input  logic [tlg_pkg::COL_FLD_W-1:0]    col,
	input  logic                             write_value,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             read_value,
	input  logic [tlg_pkg::OP_W-1:0]         done_kind,
	input  logic                             out_of_range,
	output int                               fail_count,
	output int                               pending
);
	import tlg_pkg::*;

	typedef struct packed {
		logic            read_value;
		logic [OP_W-1:0] done_kind;
		logic            out_of_range;
	} cell_result_t;

	localparam int REPORT_LIMIT = 10;

	row_t                  grid_cells [MAX_ROWS];
	logic [ROWS_REG_W-1:0] rows_reg;
	logic [COLS_REG_W-1:0] cols_reg;
	cell_result_t          awaited_results [$];

	// zero counts as one, anything past the grid saturates
	function automatic int size_in_use(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// one B3/S23 step on the nr x nc torus, all cells from the old generation
	function automatic void step_generation(input int nr, input int nc);
		row_t prior [MAX_ROWS];
		int   i, j, up, dn, lf, rt, n;
		prior = grid_cells;
		for (i = 0; i < nr; i++) begin
			up = (i + nr - 1) % nr;
			dn = (i + 1) % nr;
			for (j = 0; j < nc; j++) begin
				lf = (j + nc - 1) % nc;
				rt = (j + 1) % nc;
				n = prior[up][lf] + prior[up][j] + prior[up][rt]
				  + prior[i][lf] + prior[i][rt]
				  + prior[dn][lf] + prior[dn][j] + prior[dn][rt];
				if (n == BIRTH_CNT)
					grid_cells[i][j] = 1'b1;
				else if (n != KEEP_CNT)
					grid_cells[i][j] = 1'b0;
			end
		end
	endfunction

	function automatic cell_result_t apply_cell_item(input logic [OP_W-1:0] kind,
		input logic [ROW_FLD_W-1:0] r, input logic [COL_FLD_W-1:0] c, input logic v);
		cell_result_t res;
		int           nr, nc;
		nr = size_in_use(rows_reg, MAX_ROWS);
		nc = size_in_use(cols_reg, MAX_COLS);
		res = '0;
		res.done_kind = kind;
		if (kind == OP_WRITE || kind == OP_READ) begin
			if (r >= nr || c >= nc)
				res.out_of_range = 1'b1;
			else if (kind == OP_WRITE)
				grid_cells[r][c] = v;
			else
				res.read_value = grid_cells[r][c];
		end else if (kind == OP_ADV) begin
			step_generation(nr, nc);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			foreach (grid_cells[i])
				grid_cells[i] = '0;
			rows_reg = ROWS_RST;
			cols_reg = COLS_RST;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_COLS)
					cols_reg = pwdata[COLS_REG_W-1:0];
				else
					rows_reg = pwdata[ROWS_REG_W-1:0];
			end
			// compare before predicting: a result never belongs to this edge's item
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display({"%0t: unexpected result item: ",
							"read_value %0d done_kind %0d out_of_range %0d"},
							$realtime, read_value, done_kind, out_of_range);
				end else begin
					want = awaited_results.pop_front();
					if (want.read_value !== read_value || want.done_kind !== done_kind
						|| want.out_of_range !== out_of_range) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"%0t: result mismatch: ",
								"expected rv %0d kind %0d oor %0d, ",
								"got rv %0d kind %0d oor %0d"},
								$realtime, want.read_value, want.done_kind,
								want.out_of_range, read_value, done_kind, out_of_range);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_cell_item(op, row, col, write_value));
			pending = awaited_results.size();
		end
	end

endmodule

### tb/tb_toroidal_life_generation.sv
// ---------------------------------------------------------------------------
// tb_toroidal_life_generation
// Drives cell writes, reads and generation steps into the toroidal life block
// over a series of grid sizes, with bursty input and a patterned stall on the
// result side; a side checker predicts every result item and counts errors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_toroidal_life_generation;
	import tlg_pkg::*;

	// op code 3 has no function in the block; it must still echo back
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int ITEM_TARGET     = 1270;  // ~20 directed + ~1250 random
	localparam int ITEMS_PER_PHASE = 60;
	localparam int FIXED_PHASES    = 9;
	localparam int SETTLE_CYCLES   = 40;    // outlasts the longest advance, at 32 rows
	localparam int HOLD_CYCLES     = 300;   // long result-side hold-off
	localparam int IDLE_LIMIT      = 3000;  // cycles with no item moving

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      op;
	logic [ROW_FLD_W-1:0] row;
	logic [COL_FLD_W-1:0] col;
	logic                 write_value;
	logic                 out_valid;
	logic                 out_stall;
	logic                 read_value;
	logic [OP_W-1:0]      done_kind;
	logic                 out_of_range;

	int fail_count;
	int pending;

	// sizes as the block sees them, kept for aiming the stimulus
	int nr = 30;
	int nc = 90;
	int anchor_r, anchor_c;
	int item_count  = 0;
	int burst_left  = 0;
	int idle_cycles = 0;
	bit hold_req    = 1'b0;

	toroidal_life_generation uut (.*);

	tlg_life_checker life_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int size_in_use(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Every task below starts and ends at a falling edge at which in_valid has
	// not yet been assigned, so valid never gets two updates in one step.

	task automatic pause_input();
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
	endtask

	task automatic send_item(input logic [OP_W-1:0] kind, input logic [ROW_FLD_W-1:0] r,
		input logic [COL_FLD_W-1:0] c, input logic v);
		int gap;
		// bursts of random length; the gap before a burst may be zero
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1, 2:    gap = $urandom_range(1, 4);
				default: gap = $urandom_range(5, 45);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid    <= 1'b1;
		op          <= kind;
		row         <= r;
		col         <= c;
		write_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		item_count++;
		@(negedge clk);
	endtask

	// setup cycle, access cycle, then back to idle
	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// sizes only change with the block drained and quiet
	task automatic reconfigure(input int unsigned rv, input int unsigned cv);
		pause_input();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_ROWS, APB_DW'(rv));
		write_reg(REG_COLS, APB_DW'(cv));
		nr = size_in_use(rv, MAX_ROWS);
		nc = size_in_use(cv, MAX_COLS);
		anchor_r = $urandom_range(0, nr - 1);
		anchor_c = $urandom_range(0, nc - 1);
	endtask

	// Loose mix. Cell picks cluster around an anchor so that big grids still
	// grow live neighbourhoods, wrapping past the edges now and then.
	task automatic random_item();
		int pick, r, c;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			r = $urandom_range(0, nr - 1);
			c = $urandom_range(0, nc - 1);
		end else begin
			r = (anchor_r + $urandom_range(0, 7)) % nr;
			c = (anchor_c + $urandom_range(0, 11)) % nc;
		end
		if (pick < 50)
			send_item(OP_WRITE, ROW_FLD_W'(r), COL_FLD_W'(c), $urandom_range(0, 99) < 45);
		else if (pick < 78)
			send_item(OP_READ, ROW_FLD_W'(r), COL_FLD_W'(c), 1'($urandom));
		else if (pick < 88)
			send_item(OP_ADV, ROW_FLD_W'($urandom), COL_FLD_W'($urandom), 1'($urandom));
		else if (pick < 97)
			// any address at all: mostly lands outside small regions
			send_item(pick[0] ? OP_READ : OP_WRITE, ROW_FLD_W'($urandom),
				COL_FLD_W'($urandom), 1'($urandom));
		else
			send_item(OP_SPARE, ROW_FLD_W'($urandom), COL_FLD_W'($urandom), 1'($urandom));
	endtask

	// Well-formed round on a small region: seed every cell, then twice over
	// step one to four generations and read the whole region back.
	task automatic pattern_round();
		int r, c, pass;
		for (r = 0; r < nr; r++)
			for (c = 0; c < nc; c++)
				send_item(OP_WRITE, ROW_FLD_W'(r), COL_FLD_W'(c), $urandom_range(0, 99) < 40);
		for (pass = 0; pass < 2; pass++) begin
			repeat ($urandom_range(1, 4))
				send_item(OP_ADV, ROW_FLD_W'($urandom), COL_FLD_W'($urandom), 1'($urandom));
			for (r = 0; r < nr; r++)
				for (c = 0; c < nc; c++)
					send_item(OP_READ, ROW_FLD_W'(r), COL_FLD_W'(c), 1'($urandom));
		end
	endtask

	// Result side: stall mode changes every so often (none, light, heavy,
	// fixed 1-in-4 pattern); a hold request forces one long solid stall.
	initial begin
		int stall_mode, mode_left;
		stall_mode = 0;
		mode_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 200);
				end
				mode_left--;
				case (stall_mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= $urandom_range(0, 99) < 25;
					2:       out_stall <= $urandom_range(0, 99) < 75;
					default: out_stall <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	// watchdog: a stretch with nothing moving on either channel ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned rows_list [FIXED_PHASES];
		int unsigned cols_list [FIXED_PHASES];
		int unsigned rv, cv;
		int          phase, phase_end;

		// full size, single cell, zero sizes, saturation, tiny tori,
		// single row / single column, and the reset sizes written back
		rows_list = '{32,  1, 0,  63, 2,   1, 32, 3, 30};
		cols_list = '{128, 1, 0, 255, 2, 128,  1, 4, 90};

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_WRITE;
		row         = '0;
		col         = '0;
		write_value = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, at the reset sizes (30 x 90). Cells start dead; the four
		// corners then see each other across the wrap.
		send_item(OP_READ,  5'd0,  7'd0,  1'b1);
		send_item(OP_READ,  5'd29, 7'd89, 1'b0);
		send_item(OP_WRITE, 5'd0,  7'd0,  1'b1);
		send_item(OP_WRITE, 5'd29, 7'd89, 1'b1);
		send_item(OP_WRITE, 5'd0,  7'd89, 1'b1);
		send_item(OP_WRITE, 5'd29, 7'd0,  1'b1);
		send_item(OP_READ,  5'd0,  7'd0,  1'b0);
		// just outside the region, and the field maxima
		send_item(OP_WRITE, 5'd30, 7'd0,   1'b1);
		send_item(OP_WRITE, 5'd0,  7'd90,  1'b1);
		send_item(OP_READ,  5'd31, 7'd127, 1'b1);
		send_item(OP_READ,  5'd29, 7'd90,  1'b0);
		send_item(OP_SPARE, 5'd31, 7'd127, 1'b1);
		send_item(OP_ADV,   5'd0,  7'd0,   1'b0);
		send_item(OP_READ,  5'd0,  7'd0,   1'b0);
		send_item(OP_READ,  5'd29, 7'd89,  1'b0);
		send_item(OP_READ,  5'd1,  7'd1,   1'b0);
		send_item(OP_ADV,   5'd31, 7'd127, 1'b1);
		send_item(OP_WRITE, 5'd0,  7'd0,   1'b0);
		send_item(OP_READ,  5'd0,  7'd0,   1'b0);
		send_item(OP_SPARE, 5'd0,  7'd0,   1'b0);
		send_item(OP_READ,  5'd15, 7'd45,  1'b0);

		// Random phases, each behind a drain and a size change. Grid contents
		// carry over, so cells outside a shrunk region are seen again later.
		phase = 0;
		while (item_count < ITEM_TARGET) begin
			if (phase < FIXED_PHASES) begin
				rv = rows_list[phase];
				cv = cols_list[phase];
			end else if ($urandom_range(0, 3) != 0) begin
				rv = $urandom_range(1, 8);
				cv = $urandom_range(1, 12);
			end else begin
				rv = $urandom_range(0, 63);
				cv = $urandom_range(0, 255);
			end
			reconfigure(rv, cv);
			// long result hold-off while the sender keeps offering
			if (phase % 7 == 1)
				hold_req = 1'b1;
			if (phase == 0) begin
				send_item(OP_WRITE, 5'd31, 7'd127, 1'b1);
				send_item(OP_READ,  5'd31, 7'd127, 1'b0);
			end
			phase_end = item_count + ITEMS_PER_PHASE;
			while (item_count < phase_end) begin
				if (nr * nc <= 48 && $urandom_range(0, 2) != 0)
					pattern_round();
				else
					random_item();
			end
			phase++;
		end

		pause_input();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
